### rtl/ele_pkg.sv
// Shared types and constants of the echo line editor.
// Character codes, the sequencer state and mode types and the error text table.
// No dependencies.
`default_nettype none

package ele_pkg;

    localparam logic [7:0] CH_BS  = 8'd8;
    localparam logic [7:0] CH_LF  = 8'd10;
    localparam logic [7:0] CH_CR  = 8'd13;
    localparam logic [7:0] CH_SP  = 8'd32;
    localparam logic [7:0] CH_DEL = 8'd127;

    localparam int ERR_LEN = 25;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ECHO,
        ST_NL,
        ST_RD,
        ST_LINE,
        ST_BS,
        ST_ERR
    } t_state;

    typedef enum logic [1:0] {
        MD_ENTER,
        MD_BS,
        MD_STORE,
        MD_ERR
    } t_mode;

    // "\nError: Command too long\n", one character per index
    function automatic logic [7:0] err_char(input logic [4:0] idx);
        logic [7:0] ch;
        case (idx)
            5'd0:    ch = CH_LF;
            5'd1:    ch = 8'h45; // E
            5'd2:    ch = 8'h72; // r
            5'd3:    ch = 8'h72; // r
            5'd4:    ch = 8'h6f; // o
            5'd5:    ch = 8'h72; // r
            5'd6:    ch = 8'h3a; // :
            5'd7:    ch = CH_SP;
            5'd8:    ch = 8'h43; // C
            5'd9:    ch = 8'h6f; // o
            5'd10:   ch = 8'h6d; // m
            5'd11:   ch = 8'h6d; // m
            5'd12:   ch = 8'h61; // a
            5'd13:   ch = 8'h6e; // n
            5'd14:   ch = 8'h64; // d
            5'd15:   ch = CH_SP;
            5'd16:   ch = 8'h74; // t
            5'd17:   ch = 8'h6f; // o
            5'd18:   ch = 8'h6f; // o
            5'd19:   ch = CH_SP;
            5'd20:   ch = 8'h6c; // l
            5'd21:   ch = 8'h6f; // o
            5'd22:   ch = 8'h6e; // n
            5'd23:   ch = 8'h67; // g
            5'd24:   ch = CH_LF;
            default: ch = CH_LF;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

### rtl/echo_line_editor.sv
// Echo line editor: each accepted input byte but an empty line's end is echoed from the
// ECHO state into the output register; the input stays closed until its last result is
// emitted. A stored line byte takes an ST_RD and an ST_LINE step, as the buffer read
// port is registered. Results drain through one output register, held up by a stalled
// master side. Reset (synchronous, active low) empties the line and drops any pending
// result; the line buffer is not cleared, only bytes below the fill count are read.
// Depends on ele_pkg.
`default_nettype none

module echo_line_editor
    import ele_pkg::*;
#(
    parameter int LINE_LEN = 32
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // input stream
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] rx_byte
    // output stream
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
    output logic            m_axis_tuser,   // [0] is_line_byte
    output logic            m_axis_tlast    // last result of this input's run
);

    localparam int AW    = $clog2(LINE_LEN);
    localparam int CNT_W = (AW > 5) ? AW : 5;

    // Sequencer and datapath registers
    t_state           r_state, n_state;
    t_mode            r_mode, n_mode;
    logic [7:0]       r_char, n_char;
    logic [AW-1:0]    r_fill, n_fill;
    logic [AW-1:0]    r_len, n_len;
    logic             r_bs_more, n_bs_more;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [7:0]       r_rd;

    // Output register
    logic             r_ov, n_ov;
    logic [7:0]       r_ob, n_ob;
    logic             r_ol, n_ol;
    logic             r_olast, n_olast;

    // Line buffer
    logic [7:0]       r_mem [LINE_LEN];

    logic             w_acc, w_eol, w_bsp, w_empty, w_room, w_free;
    logic             w_emit, w_line, w_last;
    logic [7:0]       w_byte;
    logic             w_line_end;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_acc         = s_axis_tvalid && s_axis_tready;
    assign w_eol         = s_axis_tdata inside {CH_CR, CH_LF};
    assign w_bsp         = s_axis_tdata inside {CH_BS, CH_DEL};
    assign w_empty       = (r_fill == '0);
    assign w_room        = (r_fill < AW'(LINE_LEN - 1));
    // The output slot takes a new byte when empty or being drained this cycle
    assign w_free        = !r_ov || m_axis_tready;
    assign w_line_end    = (r_cnt == (CNT_W'(r_len) - CNT_W'(1)));

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                // Drop line ends on an empty line without any result
                if (w_acc && !(w_eol && w_empty)) begin
                    n_state = ST_ECHO;
                end
            end
            ST_ECHO: begin
                if (w_free) begin
                    case (r_mode)
                        MD_ENTER: n_state = ST_NL;
                        MD_BS:    n_state = r_bs_more ? ST_BS : ST_IDLE;
                        MD_ERR:   n_state = ST_ERR;
                        default:  n_state = ST_IDLE;
                    endcase
                end
            end
            ST_NL: begin
                if (w_free) begin
                    n_state = ST_RD;
                end
            end
            ST_RD: begin
                n_state = ST_LINE;
            end
            ST_LINE: begin
                if (w_free) begin
                    n_state = w_line_end ? ST_IDLE : ST_RD;
                end
            end
            ST_BS: begin
                if (w_free && r_cnt == CNT_W'(2)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_ERR: begin
                if (w_free && r_cnt == CNT_W'(ERR_LEN - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Emitted byte of the current step
    always_comb begin
        w_emit = 1'b0;
        w_byte = r_char;
        w_line = 1'b0;
        w_last = 1'b0;
        case (r_state)
            ST_ECHO: begin
                w_emit = w_free;
                w_byte = r_char;
                w_last = (r_mode == MD_STORE) || (r_mode == MD_BS && !r_bs_more);
            end
            ST_NL: begin
                w_emit = w_free;
                w_byte = CH_LF;
            end
            ST_LINE: begin
                w_emit = w_free;
                w_byte = r_rd;
                w_line = 1'b1;
                w_last = w_line_end;
            end
            ST_BS: begin
                w_emit = w_free;
                w_byte = (r_cnt == CNT_W'(1)) ? CH_SP : CH_BS;
                w_last = (r_cnt == CNT_W'(2));
            end
            ST_ERR: begin
                w_emit = w_free;
                w_byte = err_char(r_cnt[4:0]);
                w_last = (r_cnt == CNT_W'(ERR_LEN - 1));
            end
            default: begin
                w_emit = 1'b0;
            end
        endcase
    end

    // Datapath next values
    always_comb begin
        n_mode    = r_mode;
        n_char    = r_char;
        n_fill    = r_fill;
        n_len     = r_len;
        n_bs_more = r_bs_more;
        n_cnt     = r_cnt;
        n_ov      = r_ov;
        n_ob      = r_ob;
        n_ol      = r_ol;
        n_olast   = r_olast;

        if (w_acc) begin
            n_char    = s_axis_tdata;
            n_len     = r_fill;
            n_bs_more = !w_empty;
            n_cnt     = '0;
            if (w_eol) begin
                n_mode = MD_ENTER;
                n_fill = '0;
            end else if (w_bsp) begin
                n_mode = MD_BS;
                if (!w_empty) begin
                    n_fill = r_fill - AW'(1);
                end
            end else if (w_room) begin
                n_mode = MD_STORE;
                n_fill = r_fill + AW'(1);
            end else begin
                // Overflow: drop the byte and clear the line
                n_mode = MD_ERR;
                n_fill = '0;
            end
        end

        // Step the counter on each BS, ERR or LINE byte; echo and NL bytes zero it
        if (w_emit) begin
            if (r_state == ST_BS || r_state == ST_ERR || r_state == ST_LINE) begin
                n_cnt = r_cnt + CNT_W'(1);
            end else begin
                n_cnt = '0;
            end
        end

        if (w_emit) begin
            n_ov    = 1'b1;
            n_ob    = w_byte;
            n_ol    = w_line;
            n_olast = w_last;
        end else if (m_axis_tready) begin
            n_ov = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fill  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode    <= n_mode;
        r_char    <= n_char;
        r_len     <= n_len;
        r_bs_more <= n_bs_more;
        r_cnt     <= n_cnt;
        r_ob      <= n_ob;
        r_ol      <= n_ol;
        r_olast   <= n_olast;
    end

    // Line buffer: write the stored byte at the fill count, read one byte per line step
    always_ff @(posedge i_clk) begin
        if (w_acc && !w_eol && !w_bsp && w_room) begin
            r_mem[r_fill] <= s_axis_tdata;
        end
        if (r_state == ST_RD) begin
            r_rd <= r_mem[r_cnt[AW-1:0]];
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_ob;
    assign m_axis_tuser  = r_ol;
    assign m_axis_tlast  = r_olast;

`ifndef SYNTHESIS
    // A stored byte grows the line by exactly one
    a_store_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && !w_eol && !w_bsp && w_room) |=> (r_fill == $past(r_fill) + AW'(1)))
        else $error("fill count did not advance on a stored byte");

    // Any line end empties the line
    a_eol_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_eol) |=> (r_fill == '0))
        else $error("line not cleared after line end");

    // Line bytes only come from a nonempty line
    a_line_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LINE) |-> (r_len != '0))
        else $error("line bytes streamed from an empty line");
`endif

endmodule

`default_nettype wire

### dv/echo_line_editor_checker.sv
// Checker for the echo line editor: watches both stream channels, predicts the echo,
// line and error output of every accepted input byte and compares each output transaction.
// Depends on ele_pkg for the character codes and the error text length.
`default_nettype none

module echo_line_editor_checker
    import ele_pkg::*;
#(
    parameter int LINE_LEN = 32
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_tvalid,
    input  wire logic       i_s_tready,
    input  wire logic [7:0] i_s_tdata,   // [7:0] rx_byte
    input  wire logic       i_m_tvalid,
    input  wire logic       i_m_tready,
    input  wire logic [7:0] i_m_tdata,   // [7:0] out_byte
    input  wire logic       i_m_tuser,   // [0] is_line_byte
    input  wire logic       i_m_tlast,
    output int              o_fail_count,
    output int              o_pending
);

    localparam logic [ERR_LEN*8-1:0] ERR_TEXT = "\nError: Command too long\n";
    localparam int MAX_REPORTS = 200;

    typedef struct packed {
        logic       line_flag;
        logic [7:0] code;
        logic       last;
    } t_echo_result;

    t_echo_result echo_queue[$];
    logic [7:0]   line_buf[LINE_LEN];
    int           line_fill;
    int           mismatch_count = 0;
    int           pending_count = 0;

    assign o_fail_count = mismatch_count;
    assign o_pending    = pending_count;

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Work out every output byte one received byte causes and update the line.
    task automatic predict_echo(input logic [7:0] rx);
        logic [7:0]   codes[$];
        bit           flags[$];
        t_echo_result res;
        bit           is_end;
        int           i;
        is_end = (rx == CH_CR) || (rx == CH_LF);
        if (line_fill >= LINE_LEN)
            line_fill = 0;
        if (is_end && line_fill == 0)
            return;
        codes.push_back(rx);
        flags.push_back(1'b0);
        if (is_end) begin
            codes.push_back(CH_LF);
            flags.push_back(1'b0);
            for (i = 0; i < line_fill; i++) begin
                codes.push_back(line_buf[i]);
                flags.push_back(1'b1);
            end
            line_fill = 0;
        end else if (rx == CH_BS || rx == CH_DEL) begin
            if (line_fill > 0) begin
                line_fill--;
                codes.push_back(CH_BS);
                codes.push_back(CH_SP);
                codes.push_back(CH_BS);
                repeat (3) flags.push_back(1'b0);
            end
        end else if (line_fill < LINE_LEN - 1) begin
            line_buf[line_fill] = rx;
            line_fill++;
        end else begin
            line_fill = 0;
            for (i = 0; i < ERR_LEN; i++) begin
                codes.push_back(ERR_TEXT[(ERR_LEN-1-i)*8 +: 8]);
                flags.push_back(1'b0);
            end
        end
        for (i = 0; i < codes.size(); i++) begin
            res.line_flag = flags[i];
            res.code      = codes[i];
            res.last      = (i == codes.size() - 1);
            echo_queue.push_back(res);
        end
    endtask

    task automatic check_result();
        t_echo_result exp;
        if (echo_queue.size() == 0) begin
            report_mismatch($sformatf("unexpected output byte 0x%02h user %0b last %0b",
                                      i_m_tdata, i_m_tuser, i_m_tlast));
            return;
        end
        exp = echo_queue.pop_front();
        if (i_m_tuser !== exp.line_flag)
            report_mismatch($sformatf("tuser %0b, expected %0b (byte 0x%02h)",
                                      i_m_tuser, exp.line_flag, exp.code));
        if (i_m_tdata !== exp.code)
            report_mismatch($sformatf("tdata 0x%02h, expected 0x%02h",
                                      i_m_tdata, exp.code));
        if (i_m_tlast !== exp.last)
            report_mismatch($sformatf("tlast %0b, expected %0b (byte 0x%02h)",
                                      i_m_tlast, exp.last, exp.code));
    endtask

    // An output can never stem from the input accepted at the same edge, so
    // check first and predict after.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            line_fill = 0;
            echo_queue.delete();
        end else begin
            if (i_m_tvalid && i_m_tready)
                check_result();
            if (i_s_tvalid && i_s_tready)
                predict_echo(i_s_tdata);
        end
        pending_count <= echo_queue.size();
    end

endmodule

`default_nettype wire

### dv/echo_line_editor_tb.sv
// Top of the echo line editor testbench: clock, reset, input byte stimulus and
// output back-pressure, plus the final verdict.
// Depends on ele_pkg, echo_line_editor and echo_line_editor_checker.
`default_nettype none

module echo_line_editor_tb;
    import ele_pkg::*;

    localparam int LINE_LEN     = 32;
    localparam int RANDOM_ITEMS = 310;
    // stop idling once this many bytes have been sent
    localparam int QUIET_AFTER  = 250;
    // the longest run streams all LINE_LEN-1 stored bytes of a full line; leave some slack
    localparam int TAIL_CYCLES  = 80;
    // slowest run: ~350 items, each up to 33 results, each result slowed by a tready
    // stall and the block's own steps, plus an input gap per item; take a wide margin
    localparam int CYCLE_LIMIT  = 600000;

    logic       i_clk;
    logic       i_rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;
    logic       m_axis_tuser;
    logic       m_axis_tlast;

    int fail_count;
    int pending;
    int cycle_count;
    int typed_count;
    bit idle_on;

    echo_line_editor #(
        .LINE_LEN(LINE_LEN)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    echo_line_editor_checker #(
        .LINE_LEN(LINE_LEN)
    ) checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_axis_tvalid),
        .i_s_tready  (s_axis_tready),
        .i_s_tdata   (s_axis_tdata),
        .i_m_tvalid  (m_axis_tvalid),
        .i_m_tready  (m_axis_tready),
        .i_m_tdata   (m_axis_tdata),
        .i_m_tuser   (m_axis_tuser),
        .i_m_tlast   (m_axis_tlast),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Hard stop in case the block hangs or never drains its results.
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    // Output back-pressure: drop tready in random bursts while
    // idling is on, otherwise hold it high. Updates happen at falling edges.
    initial begin : ready_gen
        int n;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (idle_on && $urandom_range(0, 4) == 0) begin
                n = $urandom_range(1, 8);
                m_axis_tready <= 1'b0;
                repeat (n - 1) @(negedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Present one byte and hold it until the transaction completes. An optional
    // idle burst goes first; tvalid stays high between back-to-back bytes.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        typed_count++;
    endtask

    // Type n characters and end the line with return or line feed. A mixed line
    // also carries backspaces and now and then an arbitrary byte.
    task automatic send_line(input int n, input bit mixed);
        int i;
        for (i = 0; i < n; i++) begin
            if (mixed && $urandom_range(0, 6) == 0)
                send_byte($urandom_range(0, 1) ? CH_BS : CH_DEL);
            else if (mixed && $urandom_range(0, 15) == 0)
                send_byte(8'($urandom_range(0, 255)));
            else
                send_byte(8'($urandom_range(8'h20, 8'h7e)));
        end
        send_byte($urandom_range(0, 1) ? CH_CR : CH_LF);
    endtask

    initial begin : stimulus
        int kind;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        idle_on       = 1'b1;
        typed_count   = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: line ends and backspaces on an empty line, extreme codes,
        // both erase codes, then both line ends with content.
        send_byte(CH_CR);
        send_byte(CH_LF);
        send_byte(CH_BS);
        send_byte(CH_DEL);
        send_byte(8'h00);
        send_byte(8'hff);
        send_byte(8'h41);
        send_byte(CH_BS);
        send_byte(CH_DEL);
        send_byte(8'h7e);
        send_byte(CH_LF);
        send_byte(8'h80);
        send_byte(CH_CR);

        // Random: a full line and an overflowing one first, then a mix of
        // ordinary lines, full lines, overflows and raw noise.
        send_line(LINE_LEN - 1, 1'b0);
        send_line(LINE_LEN, 1'b0);
        while (typed_count < RANDOM_ITEMS) begin
            if (typed_count >= QUIET_AFTER)
                idle_on = 1'b0;
            kind = $urandom_range(0, 9);
            case (kind)
                0: begin
                    repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
                end
                1: begin
                    send_line(LINE_LEN - 1, 1'b0);
                end
                2: begin
                    send_line($urandom_range(LINE_LEN, LINE_LEN + 4), 1'b0);
                end
                default: begin
                    send_line($urandom_range(0, 14), 1'b1);
                end
            endcase
        end
        idle_on = 1'b0;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;

        // Drain: wait for every expected byte, then let a last run settle.
        while (pending != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
